>>> rtl/core/uart8n1_pkg.sv
package uart8n1_pkg;

  // Send queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame geometry: 8 data bits, counted 0..7
  localparam int BYTE_W    = 8;
  localparam int BITCNT_W  = $clog2(BYTE_W);
  localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(BYTE_W - 1);

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  // Line levels
  localparam logic START_LEVEL = 1'b0;
  localparam logic STOP_LEVEL  = 1'b1;
  localparam logic IDLE_LEVEL  = 1'b1;

  typedef struct packed {
    logic              op;
    logic              line_in;
    logic [BYTE_W-1:0] push_byte;
  } in_item_t;

  typedef struct packed {
    logic              line_out;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_out;
    logic              sender_idle;
    logic              push_dropped;
  } out_item_t;

  // Receiver result for one item
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_result_t;

  // Transmitter status after one item
  typedef struct packed {
    logic line;
    logic idle;
    logic dropped;
  } tx_status_t;

endpackage

>>> rtl/core/uart8n1_in_if.sv
interface uart8n1_in_if;
  import uart8n1_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

>>> rtl/core/uart8n1_out_if.sv
interface uart8n1_out_if;
  import uart8n1_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

>>> rtl/core/uart8n1_rx.sv
module uart8n1_rx (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  uart8n1_pkg::in_item_t   item,
  output uart8n1_pkg::rx_result_t res
);
  import uart8n1_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE = 3'b001,
    RX_DATA = 3'b010,
    RX_STOP = 3'b100
  } rx_state_t;

  rx_state_t           state_r, state_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    res       = '0;
    if (step_en && (item.op == OP_TICK)) begin
      unique case (state_r)
        RX_IDLE: begin
          if (item.line_in == START_LEVEL) begin
            shift_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = RX_DATA;
          end
        end
        RX_DATA: begin
          // shift in LSB first
          shift_nxt = {item.line_in, shift_r[BYTE_W-1:1]};
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == LAST_BIT) begin
            state_nxt = RX_STOP;
          end
        end
        RX_STOP: begin
          // a low stop bit keeps waiting here
          if (item.line_in == STOP_LEVEL) begin
            res.valid = 1'b1;
            res.data  = shift_r;
            state_nxt = RX_IDLE;
          end
        end
        default: state_nxt = RX_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RX_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule

>>> rtl/core/uart8n1_tx.sv
module uart8n1_tx (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  uart8n1_pkg::in_item_t   item,
  output uart8n1_pkg::tx_status_t status
);
  import uart8n1_pkg::*;

  typedef enum logic [2:0] {
    TX_IDLE = 3'b001,
    TX_DATA = 3'b010,
    TX_STOP = 3'b100
  } tx_state_t;

  tx_state_t           state_r, state_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic                pend_r, pend_nxt;
  logic                line_r, line_nxt;
  logic                idle_r, idle_nxt;
  logic [QPTR_W-1:0]   head_r, head_nxt;
  logic [QPTR_W-1:0]   tail_r, tail_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                pop, wr, dropped;
  logic [BYTE_W-1:0]   shift_cur;

  logic [BYTE_W-1:0]   mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0]   mem_q_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Popped byte arrives from the queue read register one tick later
  assign shift_cur = pend_r ? mem_q_r : shift_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    pend_nxt  = pend_r;
    line_nxt  = line_r;
    idle_nxt  = idle_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    pop       = 1'b0;
    wr        = 1'b0;
    dropped   = 1'b0;
    if (step_en) begin
      if (item.op == OP_PUSH) begin
        if (count_r == QCNT_W'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          wr        = 1'b1;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + 1'b1;
        end
        idle_nxt = 1'b0;
      end else begin
        unique case (state_r)
          TX_IDLE: begin
            if (count_r == '0) begin
              idle_nxt = 1'b1;
            end else begin
              pop       = 1'b1;
              pend_nxt  = 1'b1;
              head_nxt  = ptr_inc(head_r);
              count_nxt = count_r - 1'b1;
              line_nxt  = START_LEVEL;
              cnt_nxt   = '0;
              state_nxt = TX_DATA;
            end
          end
          TX_DATA: begin
            line_nxt  = shift_cur[0];
            shift_nxt = shift_cur >> 1;
            pend_nxt  = 1'b0;
            cnt_nxt   = cnt_r + 1'b1;
            if (cnt_r == LAST_BIT) begin
              state_nxt = TX_STOP;
            end
          end
          TX_STOP: begin
            line_nxt  = STOP_LEVEL;
            state_nxt = TX_IDLE;
          end
          default: state_nxt = TX_IDLE;
        endcase
      end
    end
  end

  assign status.line    = line_nxt;
  assign status.idle    = idle_nxt;
  assign status.dropped = dropped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TX_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      line_r  <= IDLE_LEVEL;
      idle_r  <= 1'b1;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      line_r  <= line_nxt;
      idle_r  <= idle_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[tail_r] <= item.push_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q_r <= mem[head_r];
    end
  end

endmodule

>>> rtl/core/uart_8n1_bit_engine_top.sv
// Bit-level 8N1 UART engine, one transaction per bit period.
// Input channel (in_ch): each transaction is either a tick (op = OP_TICK),
// carrying the sampled receive line in line_in, or a push (op = OP_PUSH),
// carrying a byte for the send queue in push_byte.
// Output channel (out_ch): exactly one transaction per input transaction,
// in order: the transmit line level after the item, a received byte with
// its valid flag, the sender idle flag and a dropped-push flag.
// Path: an accepted item is held in the input register, then stepped into the
// result register that drives out_ch; a stall can hold it in either one.
// Throughput: one transaction per cycle while out_ch.ready stays high; the
// receiver and transmitter state machines each take one step per item and the
// send queue is written or read at most once per item, with the popped byte
// landing in a read register that feeds the shifter on the following tick.
// Reset (rst_n low, synchronous): both engines idle, queue empty, line high,
// sender idle flag set, both channel stages empty. The queue storage is not
// cleared; only written entries are ever read.
// Receiver stall: while out_ch.ready is low the result register holds, the
// input register fills and then in_ch.ready drops; nothing is lost.
module uart_8n1_bit_engine_top (
  input  logic          clk,
  input  logic          rst_n,
  uart8n1_in_if.sink    in_ch,
  uart8n1_out_if.source out_ch
);
  import uart8n1_pkg::*;

  logic       stage_v_r;
  in_item_t   stage_r;
  logic       out_v_r;
  out_item_t  out_r;
  logic       step_en;
  rx_result_t rx_res;
  tx_status_t tx_stat;

  // Advance the input register whenever the result register is free or draining
  assign step_en     = stage_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready = ~stage_v_r | step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_r <= in_ch.data;
    end
  end

  // Receiver runs on ticks only
  uart8n1_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (stage_r),
    .res     (rx_res)
  );

  // Transmitter and send queue
  uart8n1_tx u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (stage_r),
    .status  (tx_stat)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_en) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r.line_out     <= tx_stat.line;
      out_r.byte_valid   <= rx_res.valid;
      out_r.byte_out     <= rx_res.data;
      out_r.sender_idle  <= tx_stat.idle;
      out_r.push_dropped <= tx_stat.dropped;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

>>> rtl/core/uart8n1_chk.sv
module uart8n1_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input uart8n1_pkg::out_item_t out_data
);

  // Byte field is zero unless a byte was received
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.byte_out == '0)
    else $error("byte_out nonzero without byte_valid");

  // A dropped push never carries a received byte
  a_drop_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.push_dropped |-> !out_data.byte_valid)
    else $error("dropped push reports a received byte");

  // A dropped push still clears the idle flag
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.push_dropped |-> !out_data.sender_idle)
    else $error("dropped push leaves sender idle");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset empties the result stage
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind uart_8n1_bit_engine_top uart8n1_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the bit-level 8N1 UART engine.
// Every input transaction (a tick carrying the sampled receive line, or a
// push into the send queue) produces exactly one result transaction. A
// behavioral copy of the receiver, the transmitter and the send queue runs
// alongside the block and predicts each result that no directed row types
// in. The monitor pops the oldest expectation and compares it field by field.
module tb_top;
  import uart8n1_pkg::*;

  // Frame phases shared by both engines: 0 idle, 1..8 data, 9 stop
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_FIRST     = 4'd1;
  localparam logic [3:0] PH_LAST_DATA = 4'd8;
  localparam logic [3:0] PH_STOP      = 4'd9;

  localparam int N_PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    in_item_t  stim;
    bit        typed;   // expected result typed in below
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  uart8n1_in_if  in_ch ();
  uart8n1_out_if out_ch ();

  uart_8n1_bit_engine_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: a private copy of both engines and the send queue
  logic [3:0]        rx_phase;
  logic [BYTE_W-1:0] rx_shift;
  logic [3:0]        tx_phase;
  logic [BYTE_W-1:0] tx_shift;
  logic [BYTE_W-1:0] q_mem [QUEUE_DEPTH];
  int                q_head;
  int                q_tail;
  int                q_count;
  logic              tx_line;
  logic              tx_idle;

  out_item_t pending_results [$];
  in_item_t  stim_q [$];
  dir_row_t  dir_rows [$];
  int        mismatch_cnt;
  int        gap_pct;     // chance in 100 that the sender idles a cycle
  int        stall_pct;   // chance in 100 that the receiver stalls a cycle

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // One step of the engine: receiver first, then transmitter on a tick;
  // enqueue (or drop) on a push. Returns the result the block must produce.
  function automatic out_item_t next_uart_result(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.op == OP_TICK) begin
      // Receiver: hunt for start, shift LSB first, deliver on a high stop
      if (rx_phase == PH_IDLE) begin
        if (it.line_in == START_LEVEL) begin
          rx_shift = '0;
          rx_phase = PH_FIRST;
        end
      end else if (rx_phase <= PH_LAST_DATA) begin
        rx_shift = {it.line_in, rx_shift[BYTE_W-1:1]};
        rx_phase = rx_phase + 4'd1;
      end else if (rx_phase == PH_STOP) begin
        // A low stop bit leaves the receiver waiting in the stop phase
        if (it.line_in == STOP_LEVEL) begin
          rx_phase     = PH_IDLE;
          r.byte_valid = 1'b1;
          r.byte_out   = rx_shift;
        end
      end else begin
        rx_phase = PH_IDLE;
      end

      // Transmitter: pop at idle, then start, 8 data bits, stop
      if (tx_phase == PH_IDLE) begin
        if (q_count == 0) begin
          // Empty queue: hold the line and flag idle
          tx_idle = 1'b1;
        end else begin
          tx_shift = q_mem[q_head];
          q_head   = (q_head + 1) % QUEUE_DEPTH;
          q_count  = q_count - 1;
          tx_line  = START_LEVEL;
          tx_phase = PH_FIRST;
        end
      end else if (tx_phase <= PH_LAST_DATA) begin
        tx_line  = tx_shift[0];
        tx_shift = tx_shift >> 1;
        tx_phase = tx_phase + 4'd1;
      end else if (tx_phase == PH_STOP) begin
        tx_line  = STOP_LEVEL;
        tx_phase = PH_IDLE;
      end else begin
        tx_phase = PH_IDLE;
      end
    end else begin
      // Full queue drops the byte; idle is cleared either way
      if (q_count >= QUEUE_DEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        q_mem[q_tail] = it.push_byte;
        q_tail        = (q_tail + 1) % QUEUE_DEPTH;
        q_count       = q_count + 1;
      end
      tx_idle = 1'b0;
    end
    r.line_out    = tx_line;
    r.sender_idle = tx_idle;
    return r;
  endfunction

  // Present one transaction, hold it until accepted, record the expectation.
  // Entered and left at a falling edge.
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // Step the predictor on every transaction, typed rows included
    pred = next_uart_result(it);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Wait until every expected result has come back
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(logic op, logic line, logic [7:0] pbyte,
                                  bit typed, out_item_t want);
    dir_row_t row;
    row.stim.op        = op;
    row.stim.line_in   = line;
    row.stim.push_byte = pbyte;
    row.typed          = typed;
    row.want           = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_tick(logic line);
    in_item_t it;
    it.op        = OP_TICK;
    it.line_in   = line;
    it.push_byte = 8'($urandom_range(255));   // ignored on ticks
    stim_q.push_back(it);
  endfunction

  function automatic void add_push(logic [7:0] pbyte);
    in_item_t it;
    it.op        = OP_PUSH;
    it.line_in   = 1'($urandom_range(1));     // ignored on pushes
    it.push_byte = pbyte;
    stim_q.push_back(it);
  endfunction

  // Occasionally slip a push in between the bits of a frame
  function automatic void maybe_push();
    if ($urandom_range(99) < 12) add_push(8'($urandom_range(255)));
  endfunction

  // Well-formed receive frame with random data; some get a low stop bit first
  function automatic void add_frame();
    logic [7:0] data;
    data = 8'($urandom_range(255));
    add_tick(START_LEVEL);
    maybe_push();
    for (int k = 0; k < BYTE_W; k++) begin
      add_tick(data[k]);
      maybe_push();
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) add_tick(START_LEVEL);
    end
    add_tick(STOP_LEVEL);
  endfunction

  // Mostly frames; also push bursts that overflow the queue, line noise and
  // idle-high stretches
  function automatic void build_traffic(int n);
    int pick;
    while (stim_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        add_frame();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 20)) add_push(8'($urandom_range(255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) add_tick(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 4)) add_tick(IDLE_LEVEL);
      end
    end
  endfunction

  // Receiver side: stall at random at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor: compare each accepted transaction with the oldest
  // expectation
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t: unexpected result line=%b valid=%b byte=%h idle=%b drop=%b",
                   $time, got.line_out, got.byte_valid, got.byte_out,
                   got.sender_idle, got.push_dropped);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.line_out     !== want.line_out   ||
            got.byte_valid   !== want.byte_valid ||
            got.byte_out     !== want.byte_out   ||
            got.sender_idle  !== want.sender_idle ||
            got.push_dropped !== want.push_dropped) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display({"%0t: result mismatch exp line=%b valid=%b byte=%h idle=%b drop=%b",
                      " got line=%b valid=%b byte=%h idle=%b drop=%b"},
                     $time, want.line_out, want.byte_valid, want.byte_out,
                     want.sender_idle, want.push_dropped, got.line_out,
                     got.byte_valid, got.byte_out, got.sender_idle, got.push_dropped);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int gaps   [N_PHASES];
    int stalls [N_PHASES];
    logic [7:0] fill_bytes [14];
    in_item_t it;

    gaps   = '{0, 78, 0, 11, 0};
    stalls = '{0, 0, 78, 11, 0};
    fill_bytes = '{8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h0F,
                   8'hF0, 8'h33, 8'hCC, 8'h96, 8'h69, 8'h12, 8'hED};

    // Known levels on every input from time zero
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;

    // Predictor reset state
    rx_phase = PH_IDLE;
    rx_shift = '0;
    tx_phase = PH_IDLE;
    tx_shift = '0;
    q_head   = 0;
    q_tail   = 0;
    q_count  = 0;
    tx_line  = IDLE_LEVEL;
    tx_idle  = 1'b1;

    // Directed rows. Typed results are {line, valid, byte, idle, drop}.
    // Receive 0xFF with an empty send queue: the sender stays idle, line high.
    add_row(OP_TICK, START_LEVEL, 8'h00, 1'b1, {1'b1, 1'b0, 8'h00, 1'b1, 1'b0});
    for (int k = 0; k < BYTE_W; k++) add_row(OP_TICK, 1'b1, 8'hFF, 1'b0, '0);
    // Low stop bit: keep waiting, nothing delivered
    add_row(OP_TICK, START_LEVEL, 8'h00, 1'b1, {1'b1, 1'b0, 8'h00, 1'b1, 1'b0});
    add_row(OP_TICK, STOP_LEVEL, 8'h00, 1'b1, {1'b1, 1'b1, 8'hFF, 1'b1, 1'b0});
    // Fill the queue: zero byte first, then all ones, then assorted patterns
    add_row(OP_PUSH, 1'b0, 8'h00, 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
    add_row(OP_PUSH, 1'b1, 8'hFF, 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
    foreach (fill_bytes[k])
      add_row(OP_PUSH, k[0], fill_bytes[k], 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
    // Queue full: drop the byte
    add_row(OP_PUSH, 1'b1, 8'hA5, 1'b1, {1'b1, 1'b0, 8'h00, 1'b0, 1'b1});
    // Start sending the zero byte
    add_row(OP_TICK, IDLE_LEVEL, 8'h00, 1'b0, '0);

    // Synchronous reset, released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) drive_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
    in_ch.valid <= 1'b0;

    // Hold off the sender until every directed result is back
    wait_drained();
    @(negedge clk);

    // Random traffic under each idling pattern
    for (int p = 0; p < N_PHASES; p++) begin
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      stim_q.delete();
      build_traffic(ITEMS_PER_PHASE);
      while (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        drive_item(it, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;

    // Drain, then keep watching for stray results before the final report
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
